@@ hdl/cau_pkg.sv @@
package cau_pkg;

    localparam int DW   = 32;             // width of one operand part
    localparam int FB   = 16;             // fraction bits
    localparam int PW   = 2 * DW + 2;     // exact add/sub/mul result before saturation
    localparam int DENW = 2 * DW;         // sum of two squares
    localparam int NW   = 2 * DW + FB;    // scaled divide numerator magnitude

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MOD = 3'd4;

    localparam logic signed [DW-1:0] RES_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] RES_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [PW-1:0] PRE_MAX = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [PW-1:0] PRE_MIN = {{(PW-DW+1){1'b1}}, {(DW-1){1'b0}}};

    typedef struct packed {
        logic [2:0]             action;
        logic signed [DW-1:0]   a_re;
        logic signed [DW-1:0]   a_im;
        logic signed [DW-1:0]   b_re;
        logic signed [DW-1:0]   b_im;
    } req_t;

    typedef struct packed {
        logic signed [DW-1:0]   res_re;
        logic signed [DW-1:0]   res_im;
        logic                   div_zero;
        logic                   overflow;
    } res_t;

    // Data handed from cell to cell
    typedef struct packed {
        logic [2:0]             action;
        logic signed [PW-1:0]   pre_re;
        logic signed [PW-1:0]   pre_im;
        logic                   dz;
        logic                   nr_neg;
        logic                   ni_neg;
        logic                   qr_sat;
        logic                   qi_sat;
        logic                   sq_sat;
        logic [DENW-1:0]        den;
        logic [NW-1:0]          rem_r;
        logic [NW-1:0]          rem_i;
        logic [DW-1:0]          q_r;
        logic [DW-1:0]          q_i;
        logic [DENW-1:0]        srem;
        logic [DW-1:0]          sroot;
    } chain_t;

    typedef struct packed {
        logic signed [DW-1:0]   v;
        logic                   ov;
    } sat_t;

    function automatic sat_t sat_pre(input logic signed [PW-1:0] x);
        sat_t r;
        r.ov = 1'b1;
        if (x > PRE_MAX)
        begin
            r.v = RES_MAX;
        end
        else if (x < PRE_MIN)
        begin
            r.v = RES_MIN;
        end
        else
        begin
            r.v  = x[DW-1:0];
            r.ov = 1'b0;
        end
        return r;
    endfunction

    // Signed quotient from magnitude, sign and a too-large mark
    function automatic sat_t sat_quo(input logic [DW-1:0] q, input logic neg,
                                     input logic big);
        sat_t r;
        r.ov = 1'b0;
        if (neg)
        begin
            if (big || (q[DW-1] && (q[DW-2:0] != '0)))
            begin
                r.v  = RES_MIN;
                r.ov = 1'b1;
            end
            else
            begin
                r.v = ~q + 1'b1;
            end
        end
        else
        begin
            if (big || q[DW-1])
            begin
                r.v  = RES_MAX;
                r.ov = 1'b1;
            end
            else
            begin
                r.v = q;
            end
        end
        return r;
    endfunction

endpackage

@@ hdl/cau_front.sv @@
module cau_front
    import cau_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  req_t    in_data,
    output logic    out_valid,
    output chain_t  out_data
);

    // stage A: products and the add/sub sum
    logic                   a_valid_reg;
    logic [2:0]             a_op_reg;
    logic signed [2*DW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_s1_reg, p_s2_reg;
    logic signed [DW:0]     sum_re_reg, sum_im_reg;

    logic signed [DW-1:0]   sq1_op, sq2_op;
    logic signed [DW:0]     sum_re_next, sum_im_next;

    always_comb
    begin
        sq1_op = (in_data.action == OP_MOD) ? in_data.a_re : in_data.b_re;
        sq2_op = (in_data.action == OP_MOD) ? in_data.a_im : in_data.b_im;
        if (in_data.action == OP_SUB)
        begin
            sum_re_next = (DW+1)'(in_data.a_re) - (DW+1)'(in_data.b_re);
            sum_im_next = (DW+1)'(in_data.a_im) - (DW+1)'(in_data.b_im);
        end
        else
        begin
            sum_re_next = (DW+1)'(in_data.a_re) + (DW+1)'(in_data.b_re);
            sum_im_next = (DW+1)'(in_data.a_im) + (DW+1)'(in_data.b_im);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_op_reg   <= in_data.action;
        p_rr_reg   <= in_data.a_re * in_data.b_re;
        p_ii_reg   <= in_data.a_im * in_data.b_im;
        p_ri_reg   <= in_data.a_re * in_data.b_im;
        p_ir_reg   <= in_data.a_im * in_data.b_re;
        p_s1_reg   <= sq1_op * sq1_op;
        p_s2_reg   <= sq2_op * sq2_op;
        sum_re_reg <= sum_re_next;
        sum_im_reg <= sum_im_next;
    end

    // stage B: combine products, divider and root setup
    logic                   b_valid_reg;
    chain_t                 b_data_reg;
    chain_t                 b_next;
    logic signed [PW-1:0]   nr, ni, mre, mim;
    logic [DENW-1:0]        den, nr_abs, ni_abs;
    logic [NW-1:0]          n_r, n_i;

    always_comb
    begin
        mre    = PW'(p_rr_reg) - PW'(p_ii_reg);
        mim    = PW'(p_ri_reg) + PW'(p_ir_reg);
        nr     = PW'(p_rr_reg) + PW'(p_ii_reg);
        ni     = PW'(p_ir_reg) - PW'(p_ri_reg);
        den    = DENW'(p_s1_reg) + DENW'(p_s2_reg);
        nr_abs = nr[PW-1] ? DENW'(-nr) : DENW'(nr);
        ni_abs = ni[PW-1] ? DENW'(-ni) : DENW'(ni);
        n_r    = {nr_abs, {FB{1'b0}}};
        n_i    = {ni_abs, {FB{1'b0}}};

        b_next        = '0;
        b_next.action = a_op_reg;
        if (a_op_reg == OP_MUL)
        begin
            b_next.pre_re = mre >>> FB;
            b_next.pre_im = mim >>> FB;
        end
        else
        begin
            b_next.pre_re = PW'(sum_re_reg);
            b_next.pre_im = PW'(sum_im_reg);
        end
        b_next.dz     = (a_op_reg == OP_DIV) && (den == '0);
        b_next.nr_neg = nr[PW-1];
        b_next.ni_neg = ni[PW-1];
        b_next.qr_sat = (n_r >> DW) >= NW'(den);
        b_next.qi_sat = (n_i >> DW) >= NW'(den);
        b_next.sq_sat = (den[DENW-1:DENW-2] != 2'b00);
        b_next.den    = den;
        b_next.rem_r  = n_r;
        b_next.rem_i  = n_i;
        b_next.srem   = den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_data_reg <= b_next;
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

@@ hdl/cau_cell.sv @@
module cau_cell
    import cau_pkg::*;
#(
    parameter int K = 0
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  chain_t  in_data,
    output logic    out_valid,
    output chain_t  out_data
);

    logic           valid_reg;
    chain_t         data_reg;
    chain_t         data_next;
    logic           ge_r, ge_i, ge_s;
    logic [DENW-1:0] trial;

    // one quotient bit for each divider and one root bit
    always_comb
    begin
        data_next = in_data;
        ge_r  = (in_data.rem_r >> K) >= NW'(in_data.den);
        ge_i  = (in_data.rem_i >> K) >= NW'(in_data.den);
        trial = (DENW'(in_data.sroot) << (K + 1)) + (DENW'(1) << (2 * K));
        ge_s  = in_data.srem >= trial;
        if (ge_r)
        begin
            data_next.rem_r  = in_data.rem_r - (NW'(in_data.den) << K);
            data_next.q_r[K] = 1'b1;
        end
        if (ge_i)
        begin
            data_next.rem_i  = in_data.rem_i - (NW'(in_data.den) << K);
            data_next.q_i[K] = 1'b1;
        end
        if (ge_s)
        begin
            data_next.srem     = in_data.srem - trial;
            data_next.sroot[K] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hdl/cau_back.sv @@
module cau_back
    import cau_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  chain_t  in_data,
    output logic    out_valid,
    output res_t    out_data
);

    logic   valid_reg;
    res_t   res_reg;
    res_t   res_next;
    sat_t   s_re, s_im;

    // select and saturate the final parts
    always_comb
    begin
        res_next = '0;
        s_re     = '0;
        s_im     = '0;
        case (in_data.action)
            OP_ADD, OP_SUB, OP_MUL:
            begin
                s_re = sat_pre(in_data.pre_re);
                s_im = sat_pre(in_data.pre_im);
                res_next.res_re   = s_re.v;
                res_next.res_im   = s_im.v;
                res_next.overflow = s_re.ov | s_im.ov;
            end
            OP_DIV:
            begin
                if (in_data.dz)
                begin
                    res_next.div_zero = 1'b1;
                end
                else
                begin
                    s_re = sat_quo(in_data.q_r, in_data.nr_neg, in_data.qr_sat);
                    s_im = sat_quo(in_data.q_i, in_data.ni_neg, in_data.qi_sat);
                    res_next.res_re   = s_re.v;
                    res_next.res_im   = s_im.v;
                    res_next.overflow = s_re.ov | s_im.ov;
                end
            end
            OP_MOD:
            begin
                res_next.res_re   = in_data.sq_sat ? RES_MAX : in_data.sroot;
                res_next.overflow = in_data.sq_sat;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = res_reg;

    a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> $past(in_valid))
        else $error("result strobe without a request in the last cell");

    a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && res_reg.div_zero) |->
        (res_reg.res_re == '0 && res_reg.res_im == '0 && !res_reg.overflow))
        else $error("divide by zero result not cleared");

    a_mod_im_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_data.action == OP_MOD) |=> (res_reg.res_im == '0 && !res_reg.div_zero))
        else $error("modulus result has imaginary part or div_zero");

endmodule

@@ hdl/complex_arithmetic_unit_core.sv @@
// Complex arithmetic unit, signed Q16.16: add, subtract, multiply, divide and
// modulus of a. A request is taken in every cycle (busy stays low) and its
// result appears on result for one cycle with result_valid high; results
// come out in request order and cannot be held off. The pipeline is the
// multiply stage and the setup stage, one cell per quotient and root bit
// (32 cells, each doing one restoring step for both divide parts and the
// square root), and one output register.
module complex_arithmetic_unit_core
    import cau_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  req_t    request,
    output logic    result_valid,
    output res_t    result
);

    logic           link_valid [0:DW];
    chain_t         link_data  [0:DW];

    assign busy = 1'b0;

    cau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .in_data   (request),
        .out_valid (link_valid[0]),
        .out_data  (link_data[0])
    );

    // chain of bit cells, most significant bit first
    for (genvar i = 0; i < DW; i++)
    begin : g_cell
        cau_cell #(
            .K (DW - 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[i]),
            .in_data   (link_data[i]),
            .out_valid (link_valid[i+1]),
            .out_data  (link_data[i+1])
        );
    end

    cau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (link_valid[DW]),
        .in_data   (link_data[DW]),
        .out_valid (result_valid),
        .out_data  (result)
    );

endmodule
